/* rtl/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
package wsd_pkg;

   // Event kinds on the response channel.
   localparam logic [1:0] KIND_HEADER = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_PING   = 2'd2;

   // Control frame types that are handled specially.
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   // Length codes in the second header byte.
   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;

   // One response item.
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [3:0]  message_type;
      logic        final_flag;
      logic        masked_flag;
      logic [63:0] frame_length;
      logic        last_of_frame;
   } rsp_type;

endpackage

/* rtl/wsd_if.sv */
// Valid/ready channel interfaces for the request bytes and the response events.
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface wsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  payload_byte;
   logic [3:0]  message_type;
   logic        final_flag;
   logic        masked_flag;
   logic [63:0] frame_length;
   logic        last_of_frame;

   modport source (output valid, output kind, output payload_byte, output message_type,
                   output final_flag, output masked_flag, output frame_length,
                   output last_of_frame, input ready);
   modport sink (input valid, input kind, input payload_byte, input message_type,
                 input final_flag, input masked_flag, input frame_length,
                 input last_of_frame, output ready);
endinterface

/* rtl/wsd_core.sv */
// Frame parser state and the per-byte update that produces at most one event.
module wsd_core
   import wsd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] rx_byte,
   output logic       res_valid,
   output rsp_type    res
);

   typedef enum logic [2:0] {
      PH_OPCODE  = 3'd0,
      PH_LENGTH  = 3'd1,
      PH_EXT     = 3'd2,
      PH_MASK    = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [2:0]  count_ff, count_in;
   logic [7:0]  opcode_ff, opcode_in;
   logic        mask_present_ff, mask_present_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_pos_ff, mask_pos_in;
   logic [63:0] length_ff, length_in;
   logic [63:0] remaining_ff, remaining_in;

   logic [63:0] remaining_dec;
   logic [7:0]  key_byte;
   logic        header_done;
   logic        length_done;

   assign remaining_dec = remaining_ff - 64'd1;

   // Key byte 0 is the first key byte received, held in the top byte.
   always_comb begin
      case (mask_pos_ff)
         2'd0:    key_byte = mask_key_ff[31:24];
         2'd1:    key_byte = mask_key_ff[23:16];
         2'd2:    key_byte = mask_key_ff[15:8];
         default: key_byte = mask_key_ff[7:0];
      endcase
   end

   // Next state and the event for the current byte.
   always_comb begin
      phase_in        = phase_ff;
      count_in        = count_ff;
      opcode_in       = opcode_ff;
      mask_present_in = mask_present_ff;
      mask_key_in     = mask_key_ff;
      mask_pos_in     = mask_pos_ff;
      length_in       = length_ff;
      remaining_in    = remaining_ff;
      res_valid       = 1'b0;
      header_done     = 1'b0;
      length_done     = 1'b0;
      res.kind          = KIND_DATA;
      res.payload_byte  = 8'd0;
      res.last_of_frame = 1'b0;

      case (phase_ff)
         PH_LENGTH: begin
            mask_present_in = rx_byte[7];
            if (rx_byte[6:0] < LEN_CODE_16) begin
               length_in   = {57'd0, rx_byte[6:0]};
               length_done = 1'b1;
            end else begin
               length_in = 64'd0;
               phase_in  = PH_EXT;
               count_in  = (rx_byte[6:0] == LEN_CODE_16) ? 3'd1 : 3'd7;
            end
         end
         PH_EXT: begin
            length_in = {length_ff[55:0], rx_byte};
            if (count_ff == 3'd0) begin
               length_done = 1'b1;
            end else begin
               count_in = count_ff - 3'd1;
            end
         end
         PH_MASK: begin
            mask_key_in = {mask_key_ff[23:0], rx_byte};
            if (count_ff == 3'd0) begin
               header_done = 1'b1;
            end else begin
               count_in = count_ff - 3'd1;
            end
         end
         PH_PAYLOAD: begin
            remaining_in = remaining_dec;
            if (mask_present_ff) begin
               mask_pos_in = mask_pos_ff + 2'd1;
            end
            if (remaining_dec == 64'd0) begin
               phase_in = PH_OPCODE;
            end
            res_valid = (opcode_ff[3:0] != OP_CLOSE) && (opcode_ff[3:0] != OP_PONG);
            res.kind = (opcode_ff[3:0] == OP_PING) ? KIND_PING : KIND_DATA;
            res.payload_byte  = mask_present_ff ? (rx_byte ^ key_byte) : rx_byte;
            res.last_of_frame = (remaining_dec == 64'd0);
         end
         default: begin
            // A continuation opcode keeps the type of the previous frame and ORs its flags in.
            if (rx_byte[3:0] == 4'd0) begin
               opcode_in = opcode_ff | rx_byte;
            end else begin
               opcode_in = rx_byte;
            end
            phase_in = PH_LENGTH;
         end
      endcase

      // After the length, either collect the key or finish the header.
      if (length_done) begin
         if (mask_present_in) begin
            phase_in = PH_MASK;
            count_in = 3'd3;
         end else begin
            header_done = 1'b1;
         end
      end

      if (header_done) begin
         mask_pos_in       = 2'd0;
         remaining_in      = length_in;
         phase_in          = (length_in != 64'd0) ? PH_PAYLOAD : PH_OPCODE;
         res_valid         = 1'b1;
         res.kind          = KIND_HEADER;
         res.payload_byte  = 8'd0;
         res.last_of_frame = (length_in == 64'd0);
      end

      res.message_type = opcode_in[3:0];
      res.final_flag   = opcode_in[7];
      res.masked_flag  = mask_present_in;
      res.frame_length = length_in;
   end

   // Parser state, updated once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_OPCODE;
         count_ff        <= 3'd0;
         opcode_ff       <= 8'd0;
         mask_present_ff <= 1'b0;
         mask_key_ff     <= 32'd0;
         mask_pos_ff     <= 2'd0;
         length_ff       <= 64'd0;
         remaining_ff    <= 64'd0;
      end else if (step) begin
         phase_ff        <= phase_in;
         count_ff        <= count_in;
         opcode_ff       <= opcode_in;
         mask_present_ff <= mask_present_in;
         mask_key_ff     <= mask_key_in;
         mask_pos_ff     <= mask_pos_in;
         length_ff       <= length_in;
         remaining_ff    <= remaining_in;
      end
   end

   // An event that ends a frame leaves the parser waiting for an opcode.
   a_last_to_opcode: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.last_of_frame |=> phase_ff == PH_OPCODE)
      else $error("parser not back at opcode after end of frame");

   // A header event loads the payload counter and restarts the key index.
   a_header_loads: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && (res.kind == KIND_HEADER)
      |=> (mask_pos_ff == 2'd0) && (remaining_ff == length_ff))
      else $error("header did not load payload counter");

   // Unmasked payload never moves the key index.
   a_unmasked_pos: assert property (@(posedge clock) disable iff (reset)
      step && (phase_ff == PH_PAYLOAD) && !mask_present_ff
      |=> mask_pos_ff == $past(mask_pos_ff))
      else $error("key index moved on unmasked payload");

endmodule

/* rtl/websocket_frame_deframer.sv */
// Top level of the WebSocket receive-side frame deframer.
//
// Received stream bytes enter on the req channel, one request per byte.
// Each byte goes into an input register, is parsed from there and
// its event, if any, lands in the response register on the rsp channel.
// Events are a header event when a frame header is complete, a data byte,
// or a ping payload byte; close and pong payload bytes give no event.
// Throughput is one byte per cycle while the receiver does not stall:
// the parser state update is a single step and the response register
// frees itself while it is being taken.
// When the receiver stalls with an event waiting, one more byte is held
// in the input register and req ready drops until the response is taken.
// Reset clears the parser to wait for an opcode byte and empties both
// registers; the block accepts requests in the first cycle after reset.
module websocket_frame_deframer
   import wsd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   wsd_req_if.sink      req_if,
   wsd_rsp_if.source    rsp_if
);

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   rsp_type    out_res_ff;
   logic       advance;
   logic       res_valid;
   rsp_type    res;

   // A held byte moves on whenever the response register is free or emptying.
   assign advance      = in_valid_ff && (!out_valid_ff || rsp_if.ready);
   assign req_if.ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
      if (req_if.valid && req_if.ready) begin
         in_byte_ff <= req_if.rx_byte;
      end
   end

   wsd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .res       (res)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= res_valid;
      end else if (rsp_if.ready) begin
         out_valid_ff <= 1'b0;
      end
      if (advance && res_valid) begin
         out_res_ff <= res;
      end
   end

   assign rsp_if.valid         = out_valid_ff;
   assign rsp_if.kind          = out_res_ff.kind;
   assign rsp_if.payload_byte  = out_res_ff.payload_byte;
   assign rsp_if.message_type  = out_res_ff.message_type;
   assign rsp_if.final_flag    = out_res_ff.final_flag;
   assign rsp_if.masked_flag   = out_res_ff.masked_flag;
   assign rsp_if.frame_length  = out_res_ff.frame_length;
   assign rsp_if.last_of_frame = out_res_ff.last_of_frame;

endmodule

/* verif/deframer_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts the deframer's response events from accepted requests and compares them.
module deframer_checker
   import wsd_pkg::*;
(
   input  logic clock,
   input  logic reset,
   wsd_req_if   req_mon,
   wsd_rsp_if   rsp_mon,
   output int   error_count,
   output int   pending_events,
   output int   checked_events
);

   typedef enum logic [2:0] {
      ST_OPCODE,
      ST_LENGTH,
      ST_EXTLEN,
      ST_KEY,
      ST_PAYLOAD
   } parse_state_type;

   // Shadow copy of the parser state.
   parse_state_type state;
   logic [2:0]   bytes_left;    // Extended length or key bytes after the current one.
   logic [7:0]   cur_opcode;
   logic         has_key;
   logic [31:0]  key_word;      // First key byte received sits in bits 31..24.
   logic [1:0]   key_idx;
   logic [63:0]  decoded_len;
   logic [63:0]  payload_left;

   // Events predicted but not yet seen on the response channel, oldest first.
   rsp_type      due_events[$];

   // Builds an event from the current frame state.
   function automatic rsp_type make_event(input logic [1:0] k, input logic [7:0] pb,
                                          input logic last);
      rsp_type e;
      e.kind          = k;
      e.payload_byte  = pb;
      e.message_type  = cur_opcode[3:0];
      e.final_flag    = cur_opcode[7];
      e.masked_flag   = has_key;
      e.frame_length  = decoded_len;
      e.last_of_frame = last;
      return e;
   endfunction

   // The header is complete: announce it and set up the payload count.
   task automatic header_done();
      key_idx      = 2'd0;
      payload_left = decoded_len;
      state        = (decoded_len != 64'd0) ? ST_PAYLOAD : ST_OPCODE;
      due_events.push_back(make_event(KIND_HEADER, 8'h00, decoded_len == 64'd0));
   endtask

   // The length is known: a masked frame still needs its four key bytes.
   task automatic length_done();
      if (has_key) begin
         state      = ST_KEY;
         bytes_left = 3'd3;
      end else begin
         header_done();
      end
   endtask

   // Advances the shadow parser by one received byte.
   task automatic decode_byte(input logic [7:0] b);
      logic [7:0] plain;
      logic [3:0] ftype;
      case (state)
         ST_LENGTH: begin
            has_key     = b[7];
            decoded_len = 64'd0;
            if (b[6:0] < LEN_CODE_16) begin
               decoded_len = {57'd0, b[6:0]};
               length_done();
            end else begin
               state      = ST_EXTLEN;
               bytes_left = (b[6:0] == LEN_CODE_16) ? 3'd1 : 3'd7;
            end
         end
         ST_EXTLEN: begin
            decoded_len = {decoded_len[55:0], b};
            if (bytes_left == 3'd0) length_done();
            else bytes_left = bytes_left - 3'd1;
         end
         ST_KEY: begin
            key_word = {key_word[23:0], b};
            if (bytes_left == 3'd0) header_done();
            else bytes_left = bytes_left - 3'd1;
         end
         ST_PAYLOAD: begin
            ftype = cur_opcode[3:0];
            plain = b;
            if (has_key) begin
               plain   = b ^ key_word[8 * (3 - key_idx) +: 8];
               key_idx = key_idx + 2'd1;
            end
            payload_left = payload_left - 64'd1;
            if (payload_left == 64'd0) state = ST_OPCODE;
            // Close and pong payloads are swallowed without an event.
            if (ftype != OP_CLOSE && ftype != OP_PONG) begin
               due_events.push_back(make_event((ftype == OP_PING) ? KIND_PING : KIND_DATA,
                                               plain, payload_left == 64'd0));
            end
         end
         default: begin
            // A continuation opcode keeps the type of the frame before it and ORs its flags in.
            if (b[3:0] == 4'h0) cur_opcode = cur_opcode | b;
            else cur_opcode = b;
            state = ST_LENGTH;
         end
      endcase
   endtask

   task automatic check_field(input string fname, input logic [63:0] want_v,
                              input logic [63:0] got_v);
      if (got_v !== want_v) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", fname, want_v, got_v);
         error_count++;
      end
   endtask

   // Responses are compared first; a request accepted at this edge cannot answer yet.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         state          = ST_OPCODE;
         bytes_left     = 3'd0;
         cur_opcode     = 8'h00;
         has_key        = 1'b0;
         key_word       = 32'd0;
         key_idx        = 2'd0;
         decoded_len    = 64'd0;
         payload_left   = 64'd0;
         due_events.delete();
         error_count    = 0;
         checked_events = 0;
      end else begin
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            if (due_events.size() == 0) begin
               $error("Response event with no request that explains it (kind %0d)",
                      rsp_mon.kind);
               error_count++;
            end else begin
               want = due_events.pop_front();
               checked_events++;
               check_field("kind", 64'(want.kind), 64'(rsp_mon.kind));
               check_field("payload_byte", 64'(want.payload_byte),
                           64'(rsp_mon.payload_byte));
               check_field("message_type", 64'(want.message_type),
                           64'(rsp_mon.message_type));
               check_field("final_flag", 64'(want.final_flag), 64'(rsp_mon.final_flag));
               check_field("masked_flag", 64'(want.masked_flag), 64'(rsp_mon.masked_flag));
               check_field("frame_length", want.frame_length, rsp_mon.frame_length);
               check_field("last_of_frame", 64'(want.last_of_frame),
                           64'(rsp_mon.last_of_frame));
            end
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) decode_byte(req_mon.rx_byte);
      end
      pending_events = due_events.size();
   end

endmodule

/* verif/websocket_frame_deframer_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the frame deframer: clock, reset, request stimulus and the verdict.
module websocket_frame_deframer_tb;
   import wsd_pkg::*;

   typedef enum int {
      LEN_SHORT,
      LEN_EXT16,
      LEN_EXT64
   } len_form_type;

   // Opcode types not named by the package.
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_RSV    = 4'h3;

   localparam int DIRECTED_LEN = 26;
   localparam int RANDOM_BYTES = 480;

   // Directed stream, first byte in the top bits.
   localparam logic [DIRECTED_LEN*8-1:0] DIRECTED_SEQ = {
      // Empty final text frame: the header event ends the frame.
      1'b1, 3'b000, OP_TEXT, 8'h00,
      // Masked first fragment with FIN clear, one payload byte.
      1'b0, 3'b000, OP_TEXT, 1'b1, 7'd1, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h3C,
      // Continuation with FIN set, merged into the stored opcode.
      1'b1, 3'b000, OP_CONT, 8'h01, 8'hFF,
      // Ping with one payload byte.
      1'b1, 3'b000, OP_PING, 8'h01, 8'h00,
      // Close and pong with payload: header event only.
      1'b1, 3'b000, OP_CLOSE, 8'h01, 8'h77,
      1'b1, 3'b000, OP_PONG, 8'h01, 8'h88,
      // Reserved type with reserved bits set and a 16-bit length that could be shorter.
      1'b1, 3'b111, OP_RSV, 1'b0, LEN_CODE_16, 8'h00, 8'h01, 8'h42
   };

   logic clock;
   logic reset;
   logic quiet;
   int   error_count;
   int   pending_events;
   int   checked_events;
   int   bytes_sent;
   int   frames_sent;

   wsd_req_if req_ch ();
   wsd_rsp_if rsp_ch ();

   websocket_frame_deframer dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_ch),
      .rsp_if(rsp_ch)
   );

   deframer_checker frame_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (error_count),
      .pending_events(pending_events),
      .checked_events(checked_events)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Receiver side: stalls now and then, except during the quiet stretch.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ch.ready = quiet || ($urandom_range(0, 99) >= 16);
      end
   end

   // Hard stop in case the block hangs.
   initial begin
      #2_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Offers one byte, with an occasional gap first, and waits for the handshake.
   task automatic send_byte(input logic [7:0] value);
      if (!quiet && $urandom_range(0, 99) < 16) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 2)) @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.rx_byte = value;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      @(negedge clock);
      bytes_sent++;
   endtask

   // Sends a whole frame: opcode, length, extended length, key and payload.
   task automatic send_frame(input logic [7:0] opcode, input logic masked,
                             input len_form_type form, input logic [63:0] len,
                             input int n_payload);
      logic [6:0] code;
      case (form)
         LEN_EXT16: code = LEN_CODE_16;
         LEN_EXT64: code = LEN_CODE_64;
         default:   code = len[6:0];
      endcase
      send_byte(opcode);
      send_byte({masked, code});
      if (form == LEN_EXT16) begin
         for (int i = 1; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
      if (form == LEN_EXT64) begin
         for (int i = 7; i >= 0; i--) send_byte(len[8 * i +: 8]);
      end
      if (masked) repeat (4) send_byte(8'($urandom_range(0, 255)));
      repeat (n_payload) send_byte(8'($urandom_range(0, 255)));
      frames_sent++;
   endtask

   // Mostly well-formed frames; a fifth start with an arbitrary opcode byte.
   task automatic send_random_frame();
      logic [7:0]   opcode;
      logic         fin;
      logic [63:0]  len;
      len_form_type form;
      fin = ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
         0, 1:    opcode = 8'($urandom_range(0, 255));
         2, 3:    opcode = {fin, 3'b000, OP_CONT};
         4, 5:    opcode = {fin, 3'b000, OP_TEXT};
         6:       opcode = {fin, 3'b000, OP_BINARY};
         7:       opcode = {1'b1, 3'b000, OP_PING};
         8:       opcode = {1'b1, 3'b000, OP_CLOSE};
         default: opcode = {1'b1, 3'b000, OP_PONG};
      endcase
      len = 64'($urandom_range(0, 12));
      case ($urandom_range(0, 19))
         0, 1:    form = LEN_EXT16;
         2:       form = LEN_EXT64;
         default: form = LEN_SHORT;
      endcase
      // A few long frames: the longest short code and one properly coded 16-bit length.
      if (form == LEN_SHORT && $urandom_range(0, 49) == 0) len = 64'd125;
      if (frames_sent == 30) begin
         form = LEN_EXT16;
         len  = 64'($urandom_range(126, 200));
      end
      send_frame(opcode, 1'($urandom_range(0, 1)), form, len, int'(len));
   endtask

   // Holds the request side until every predicted event has come out.
   task automatic hold_until_drained();
      req_ch.valid = 1'b0;
      while (pending_events != 0) @(negedge clock);
   endtask

   initial begin
      int drain_cycles;
      reset          = 1'b1;
      quiet          = 1'b0;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'h00;
      bytes_sent     = 0;
      frames_sent    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed frames: text, continuation, ping, close, pong and reserved, short and 16-bit lengths.
      for (int i = 0; i < DIRECTED_LEN; i++) begin
         send_byte(DIRECTED_SEQ[8 * (DIRECTED_LEN - 1 - i) +: 8]);
      end
      hold_until_drained();

      // Random frames, with a stretch of back-to-back traffic and one full pause.
      while (bytes_sent < DIRECTED_LEN + RANDOM_BYTES) begin
         quiet = (frames_sent >= 25 && frames_sent < 40);
         send_random_frame();
         if (frames_sent == 50) hold_until_drained();
      end
      quiet = 1'b0;

      // A 64-bit length with the top bit set never ends, so it comes last.
      send_frame({1'b1, 3'b000, OP_BINARY}, 1'b1, LEN_EXT64,
                 {1'b1, 31'($urandom), 32'($urandom)}, 20);
      req_ch.valid = 1'b0;

      drain_cycles = 0;
      while (pending_events != 0 && drain_cycles < 20000) begin
         @(negedge clock);
         drain_cycles++;
      end
      repeat (10) @(negedge clock);

      if (pending_events != 0) $error("%0d predicted events never arrived", pending_events);
      $display("Sent %0d request bytes: the directed frames and %0d random frames.",
               bytes_sent, frames_sent);
      $display("Compared %0d response events field by field.", checked_events);
      if (pending_events == 0 && error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
